// File: design/fbt_pkg.sv
// Package for the flow bulk transfer tracker.
// Field widths, configuration register indexes and saturating adders.
// No dependencies.
`default_nettype none

package fbt_pkg;

    localparam int CNT_W   = 32;
    localparam int BYTE_W  = 48;
    localparam int DUR_W   = 63;
    localparam int SIZE_W  = 16;
    localparam int TS_W    = 63;
    localparam int GAP_W   = 32;
    localparam int MINP_W  = 8;
    localparam int CFG_W   = 32;
    localparam int IN_DATA_W   = 80;
    localparam int OUT_DATA_W  = 176;
    localparam logic [MINP_W-1:0] MINP_FLOOR = 8'd2;
    localparam logic [GAP_W-1:0]  GAP_RESET  = 32'd1000000;
    localparam logic [MINP_W-1:0] MINP_RESET = 8'd4;

    typedef enum logic [0:0] {
        CFG_BULK_GAP = 1'b0,
        CFG_BULK_MIN = 1'b1
    } cfg_index_t;

    function automatic logic [CNT_W-1:0] sat_add32(input logic [CNT_W-1:0] a,
                                                   input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

    function automatic logic [BYTE_W-1:0] sat_add48(input logic [BYTE_W-1:0] a,
                                                    input logic [CNT_W-1:0] b);
        logic [BYTE_W:0] s;
        s = {1'b0, a} + {{(BYTE_W-CNT_W+1){1'b0}}, b};
        return s[BYTE_W] ? {BYTE_W{1'b1}} : s[BYTE_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: design/fbt_ram.sv
// Generic RAM: one write port, one read port with registered read data.
// Depends on nothing.
`default_nettype none

module fbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: design/flow_bulk_transfer_tracker.sv
// Flow bulk transfer tracker top level.
// Per-direction bulk state lives in fbt_ram instances; uses fbt_pkg.
//
// Usage:
//   s_axis carries one packet per transaction: tuser {from_client, new_flow},
//   tdata {timestamp_us, payload_size}. m_axis returns one result per packet:
//   tuser {in_bulk, dir_out}, tdata {bulk_duration_us, bulk_bytes,
//   bulk_packets, bulk_count}. cfg_we/cfg_index/cfg_wdata write bulk_gap_us
//   (index 0) or bulk_min_packets (index 1); write only while idle.
//   Throughput: one packet per cycle while m_axis does not stall; the output
//   register loads the result when the update stage advances.
//   The state RAM read at acceptance fills the update stage; the update and
//   write-back feed the output register.
//   A write still in flight to either direction is forwarded.
//   Reset clears both directions through per-entry valid bits (no clearing
//   pass) and loads the register defaults. When m_axis stalls, the output
//   register holds, one more packet waits in the update stage, and then
//   s_axis_tready drops.
`default_nettype none

module flow_bulk_transfer_tracker #(
    parameter int TIME_BITS = 64
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [15:0] payload_size, [78:16] timestamp_us, [79] zero
    input  wire logic [fbt_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [0] new_flow, [1] from_client
    input  wire logic [1:0]                        s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [31:0] bulk_count, [63:32] bulk_packets, [111:64] bulk_bytes,
    // [174:112] bulk_duration_us, [175] zero
    output logic      [fbt_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // [0] dir_out, [1] in_bulk
    output logic      [1:0]                        m_axis_tuser,
    input  wire logic                              cfg_we,
    input  wire logic                              cfg_index,
    input  wire logic [fbt_pkg::CFG_W-1:0]         cfg_wdata
);

    import fbt_pkg::*;

    localparam int TW = TIME_BITS;

    typedef struct packed {
        logic              open;
        logic [TW-1:0]     start;
        logic [TW-1:0]     last;
        logic [CNT_W-1:0]  cbytes;
        logic [CNT_W-1:0]  cpkts;
        logic [CNT_W-1:0]  bcount;
        logic [CNT_W-1:0]  bpkts;
        logic [BYTE_W-1:0] bbytes;
        logic [DUR_W-1:0]  btime;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    // configuration
    logic [GAP_W-1:0]  gap_reg;
    logic [MINP_W-1:0] minp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg  <= GAP_RESET;
            minp_reg <= MINP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_BULK_GAP: gap_reg  <= cfg_wdata[GAP_W-1:0];
                CFG_BULK_MIN: minp_reg <= cfg_wdata[MINP_W-1:0];
                default:      gap_reg  <= gap_reg;
            endcase
        end
    end

    // handshake
    logic in_accept;
    logic s1_valid_reg;
    logic s1_advance;
    logic out_valid_reg;

    assign s1_advance    = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    logic          in_dir;
    logic [63:0]   in_ts64;
    assign in_dir  = s_axis_tuser[1];
    assign in_ts64 = {1'b0, s_axis_tdata[SIZE_W +: TS_W]};

    // state memories: full record read at the packet's direction,
    // a copy of it read at the opposite direction for its last time
    logic       wr_en;
    logic       wr_addr;
    rec_t       wr_rec;
    logic [REC_W-1:0] rd_d;
    logic [REC_W-1:0] rd_o;

    fbt_ram #(.WIDTH(REC_W), .DEPTH(2)) u_ram_d (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_rec),
        .re    (in_accept),
        .raddr (in_dir),
        .rdata (rd_d)
    );

    fbt_ram #(.WIDTH(REC_W), .DEPTH(2)) u_ram_o (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_rec),
        .re    (in_accept),
        .raddr (!in_dir),
        .rdata (rd_o)
    );

    // update stage registers
    logic              s1_new_reg;
    logic              s1_dir_reg;
    logic [SIZE_W-1:0] s1_size_reg;
    logic [TW-1:0]     s1_now_reg;
    logic              hit_d_reg;
    logic              hit_o_reg;
    rec_t              fwd_reg;
    logic [1:0]        vld_reg;
    logic [1:0]        vld_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            vld_reg      <= 2'b00;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_new_reg  <= s_axis_tuser[0];
            s1_dir_reg  <= in_dir;
            s1_size_reg <= s_axis_tdata[SIZE_W-1:0];
            s1_now_reg  <= in_ts64[TW-1:0];
            // the RAM read misses a write on this same edge: forward it
            hit_d_reg   <= wr_en && (wr_addr == in_dir);
            hit_o_reg   <= wr_en && (wr_addr == !in_dir);
        end
        if (wr_en)
        begin
            fwd_reg <= wr_rec;
        end
    end

    // read-modify-write
    rec_t             cur;
    rec_t             nxt;
    logic [TW-1:0]    last_o;
    logic             abandon;
    logic [TW-1:0]    gap_last;
    logic [TW-1:0]    gap_start;
    logic             too_far;
    logic [CNT_W-1:0] minp32;
    logic [MINP_W-1:0] minp_eff;
    logic [DUR_W+1:0] dur_sum;
    logic [TW-1:0]    dur_add;
    logic             add_dur;

    always_comb
    begin
        rec_t o_rec;

        o_rec = rec_t'(rd_o);
        if (s1_new_reg || !vld_reg[s1_dir_reg])
        begin
            cur = '0;
        end
        else if (hit_d_reg)
        begin
            cur = fwd_reg;
        end
        else
        begin
            cur = rec_t'(rd_d);
        end

        if (s1_new_reg || !vld_reg[!s1_dir_reg])
        begin
            last_o = '0;
        end
        else if (hit_o_reg)
        begin
            last_o = fwd_reg.last;
        end
        else
        begin
            last_o = o_rec.last;
        end

        minp_eff  = (minp_reg < MINP_FLOOR) ? MINP_FLOOR : minp_reg;
        minp32    = {{(CNT_W-MINP_W){1'b0}}, minp_eff};
        abandon   = last_o > cur.start;
        gap_last  = (s1_now_reg >= cur.last)  ? (s1_now_reg - cur.last)  : '0;
        gap_start = (s1_now_reg >= cur.start) ? (s1_now_reg - cur.start) : '0;
        too_far   = gap_last > TW'(gap_reg);

        nxt      = cur;
        add_dur  = 1'b0;
        dur_add  = gap_last;
        if (abandon)
        begin
            nxt.open = 1'b0;
        end

        if (s1_size_reg != '0)
        begin
            if (!nxt.open || too_far)
            begin
                nxt.open   = 1'b1;
                nxt.cbytes = {{(CNT_W-SIZE_W){1'b0}}, s1_size_reg};
                nxt.cpkts  = {{(CNT_W-1){1'b0}}, 1'b1};
                nxt.start  = s1_now_reg;
                nxt.last   = s1_now_reg;
            end
            else
            begin
                nxt.cbytes = sat_add32(cur.cbytes, {{(CNT_W-SIZE_W){1'b0}}, s1_size_reg});
                nxt.cpkts  = sat_add32(cur.cpkts, {{(CNT_W-1){1'b0}}, 1'b1});
                if (nxt.cpkts == minp32)
                begin
                    // candidate just qualified: count it whole
                    nxt.bcount = sat_add32(cur.bcount, {{(CNT_W-1){1'b0}}, 1'b1});
                    nxt.bpkts  = sat_add32(cur.bpkts, nxt.cpkts);
                    nxt.bbytes = sat_add48(cur.bbytes, nxt.cbytes);
                    add_dur    = 1'b1;
                    dur_add    = gap_start;
                end
                else if (nxt.cpkts > minp32)
                begin
                    nxt.bpkts  = sat_add32(cur.bpkts, {{(CNT_W-1){1'b0}}, 1'b1});
                    nxt.bbytes = sat_add48(cur.bbytes,
                                           {{(CNT_W-SIZE_W){1'b0}}, s1_size_reg});
                    add_dur    = 1'b1;
                    dur_add    = gap_last;
                end
                nxt.last = s1_now_reg;
            end
        end

        dur_sum = {2'b00, cur.btime} + (DUR_W+2)'(dur_add);
        if (add_dur)
        begin
            nxt.btime = (dur_sum > {2'b00, {DUR_W{1'b1}}}) ? {DUR_W{1'b1}}
                                                            : dur_sum[DUR_W-1:0];
        end
    end

    assign wr_en   = s1_advance;
    assign wr_addr = s1_dir_reg;
    assign wr_rec  = nxt;

    always_comb
    begin
        vld_next = vld_reg;
        if (s1_advance)
        begin
            if (s1_new_reg)
            begin
                vld_next = 2'b00;
            end
            vld_next[s1_dir_reg] = 1'b1;
        end
    end

    // output register
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [1:0]            out_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_user_reg <= {nxt.open && (nxt.cpkts >= minp32), s1_dir_reg};
            out_data_reg <= {1'b0, nxt.btime, nxt.bbytes, nxt.bpkts, nxt.bcount};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

`default_nettype wire

// File: verif/flow_bulk_transfer_tracker_tb.sv
// Self-checking testbench for flow_bulk_transfer_tracker: directed packet sequences,
// then bursty random traffic under several register settings and stall patterns.
// Depends on fbt_pkg and the flow_bulk_transfer_tracker RTL.
`timescale 1ns / 1ps

module flow_bulk_transfer_tracker_tb;

    import fbt_pkg::*;

    localparam int          LIMIT_CYCLES = 200000;
    localparam logic [63:0] MAX32 = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] MAX48 = 64'h0000_FFFF_FFFF_FFFF;
    localparam logic [63:0] MAX63 = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [62:0] TS_MAX = 63'h7FFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic              new_flow;
        logic              from_client;
        logic [SIZE_W-1:0] size;
        logic [TS_W-1:0]   ts;
    } packet_t;

    typedef struct {
        logic              dir;
        logic              in_bulk;
        logic [CNT_W-1:0]  count;
        logic [CNT_W-1:0]  pkts;
        logic [BYTE_W-1:0] bytes;
        logic [DUR_W-1:0]  dur;
    } bulk_report_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0]            m_axis_tuser;
    logic                  cfg_we = 1'b0;
    logic                  cfg_index = 1'b0;
    logic [CFG_W-1:0]      cfg_wdata = '0;

    // register copies, changed only while the block is idle
    logic [GAP_W-1:0]  gap_cfg = GAP_RESET;
    logic [MINP_W-1:0] minp_cfg = MINP_RESET;

    // per-direction bulk state, index 1 is forward
    logic              cand_open [2] = '{1'b0, 1'b0};
    logic [63:0]       cand_start [2] = '{64'd0, 64'd0};
    logic [63:0]       cand_last [2] = '{64'd0, 64'd0};
    logic [CNT_W-1:0]  cand_bytes [2] = '{32'd0, 32'd0};
    logic [CNT_W-1:0]  cand_pkts [2] = '{32'd0, 32'd0};
    logic [CNT_W-1:0]  bulks [2] = '{32'd0, 32'd0};
    logic [CNT_W-1:0]  pkt_total [2] = '{32'd0, 32'd0};
    logic [BYTE_W-1:0] byte_total [2] = '{48'd0, 48'd0};
    logic [63:0]       time_total [2] = '{64'd0, 64'd0};

    packet_t      packet_q[$];
    bulk_report_t report_q[$];
    logic [62:0]  ts_cur = '0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int packets_in = 0;
    int results_in = 0;
    int bulk_reports = 0;
    int settings_run = 0;
    int cycles = 0;

    flow_bulk_transfer_tracker DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always #2 clk = ~clk;

    function automatic logic [63:0] sat_sum(input logic [63:0] a, input logic [63:0] b,
                                            input logic [63:0] lim);
        logic [63:0] x;
        x = (a > lim) ? lim : a;
        return (b > lim - x) ? lim : x + b;
    endfunction

    // time moving backward gives zero
    function automatic logic [63:0] elapsed(input logic [63:0] now, input logic [63:0] then);
        return (now >= then) ? now - then : 64'd0;
    endfunction

    function automatic bulk_report_t track_packet(input packet_t p);
        bulk_report_t r;
        int d;
        int o;
        logic [63:0] now;
        logic [63:0] minp;
        d = int'(p.from_client);
        o = 1 - d;
        now = {1'b0, p.ts};
        minp = (minp_cfg < 2) ? 64'd2 : 64'(minp_cfg);
        if (p.new_flow)
        begin
            for (int i = 0; i < 2; i++)
            begin
                cand_open[i] = 1'b0;
                cand_start[i] = '0;
                cand_last[i] = '0;
                cand_bytes[i] = '0;
                cand_pkts[i] = '0;
                bulks[i] = '0;
                pkt_total[i] = '0;
                byte_total[i] = '0;
                time_total[i] = '0;
            end
        end
        // opposite direction spoke after our candidate began: drop it
        if (cand_last[o] > cand_start[d])
            cand_open[d] = 1'b0;
        if (p.size != 0)
        begin
            if (!cand_open[d] || elapsed(now, cand_last[d]) > 64'(gap_cfg))
            begin
                cand_open[d] = 1'b1;
                cand_bytes[d] = 32'(p.size);
                cand_pkts[d] = 32'd1;
                cand_start[d] = now;
                cand_last[d] = now;
            end
            else
            begin
                cand_bytes[d] = 32'(sat_sum(64'(cand_bytes[d]), 64'(p.size), MAX32));
                cand_pkts[d] = 32'(sat_sum(64'(cand_pkts[d]), 64'd1, MAX32));
                if (64'(cand_pkts[d]) == minp)
                begin
                    bulks[d] = 32'(sat_sum(64'(bulks[d]), 64'd1, MAX32));
                    pkt_total[d] = 32'(sat_sum(64'(pkt_total[d]), 64'(cand_pkts[d]), MAX32));
                    byte_total[d] = 48'(sat_sum(64'(byte_total[d]), 64'(cand_bytes[d]),
                                                MAX48));
                    time_total[d] = sat_sum(time_total[d], elapsed(now, cand_start[d]), MAX63);
                end
                else if (64'(cand_pkts[d]) > minp)
                begin
                    pkt_total[d] = 32'(sat_sum(64'(pkt_total[d]), 64'd1, MAX32));
                    byte_total[d] = 48'(sat_sum(64'(byte_total[d]), 64'(p.size), MAX48));
                    time_total[d] = sat_sum(time_total[d], elapsed(now, cand_last[d]), MAX63);
                end
                cand_last[d] = now;
            end
        end
        r.dir = p.from_client;
        r.in_bulk = cand_open[d] && (64'(cand_pkts[d]) >= minp);
        r.count = bulks[d];
        r.pkts = pkt_total[d];
        r.bytes = byte_total[d];
        r.dur = time_total[d][62:0];
        return r;
    endfunction

    task automatic push_pkt(input logic nf, input logic fc, input logic [15:0] size,
                            input logic [62:0] ts);
        packet_t p;
        p.new_flow = nf;
        p.from_client = fc;
        p.size = size;
        p.ts = ts;
        packet_q.insert(packet_q.size(), p);
    endtask

    // both registers in back-to-back writes; minimum gets junk in the unused upper bits
    task automatic set_config(input logic [GAP_W-1:0] gap, input logic [MINP_W-1:0] minp);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_BULK_GAP;
        cfg_wdata <= gap;
        @(posedge clk);
        cfg_index <= CFG_BULK_MIN;
        cfg_wdata <= {24'($urandom), minp};
        @(posedge clk);
        cfg_we <= 1'b0;
        gap_cfg = gap;
        minp_cfg = minp;
        settings_run++;
    endtask

    // bursts of one direction within the gap limit; rough_pct of packets break the pattern
    task automatic gen_traffic(input int n, input int min_burst, input int max_burst,
                               input int rough_pct);
        int left;
        int burst;
        int pick;
        logic dir;
        logic nf;
        logic fc;
        logic [15:0] size;
        left = n;
        ts_cur = 63'({$urandom, $urandom});
        while (left > 0)
        begin
            dir = 1'($urandom_range(1, 0));
            burst = $urandom_range(max_burst, min_burst);
            for (int k = 0; k < burst && left > 0; k++)
            begin
                nf = 1'b0;
                fc = dir;
                ts_cur = ts_cur + 63'($urandom_range(gap_cfg, 0));
                if ($urandom_range(99) < rough_pct)
                begin
                    case ($urandom_range(4))
                        0: fc = !dir;
                        1: ts_cur = ts_cur + 63'(gap_cfg) + 63'd1 + 63'($urandom_range(40));
                        2: ts_cur = ts_cur - 63'($urandom_range(5000, 1));
                        3: ts_cur = 63'({$urandom, $urandom});
                        default: nf = 1'b1;
                    endcase
                end
                pick = $urandom_range(99);
                if (pick < 5)
                    size = '0;
                else if (pick < 9)
                    size = 16'hFFFF;
                else
                    size = 16'($urandom_range(65535, 1));
                push_pkt(nf, fc, size, ts_cur);
                left--;
            end
        end
    endtask

    // sample at the falling edge so the driver's pops have settled
    task automatic drain;
        @(negedge clk);
        while (packet_q.size() != 0 || s_axis_tvalid || report_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // sender
    always @(posedge clk)
    begin : driver
        packet_t p;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (packet_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                p = packet_q.pop_front();
                s_axis_tdata <= {1'b0, p.ts, p.size};
                s_axis_tuser <= {p.from_client, p.new_flow};
                s_axis_tvalid <= 1'b1;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin : monitor
        packet_t seen;
        bulk_report_t want;
        bulk_report_t got;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                seen.new_flow = s_axis_tuser[0];
                seen.from_client = s_axis_tuser[1];
                seen.size = s_axis_tdata[15:0];
                seen.ts = s_axis_tdata[78:16];
                report_q.insert(report_q.size(), track_packet(seen));
                packets_in++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.dir = m_axis_tuser[0];
                got.in_bulk = m_axis_tuser[1];
                got.count = m_axis_tdata[31:0];
                got.pkts = m_axis_tdata[63:32];
                got.bytes = m_axis_tdata[111:64];
                got.dur = m_axis_tdata[174:112];
                results_in++;
                if (got.in_bulk === 1'b1)
                    bulk_reports++;
                if (report_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] result with no packet pending: dir=%0d cnt=%0d",
                                 $realtime, got.dir, got.count);
                end
                else
                begin
                    want = report_q.pop_front();
                    if (got.dir !== want.dir || got.in_bulk !== want.in_bulk ||
                        got.count !== want.count || got.pkts !== want.pkts ||
                        got.bytes !== want.bytes || got.dur !== want.dur)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("[%0t] result %0d expected ", $realtime, results_in,
                                     "dir=%0d bulk=%0d cnt=%0d ",
                                     want.dir, want.in_bulk, want.count,
                                     "pkts=%0d bytes=%0d dur=%0d",
                                     want.pkts, want.bytes, want.dur);
                            $display("              got      dir=%0d bulk=%0d cnt=%0d ",
                                     got.dir, got.in_bulk, got.count,
                                     "pkts=%0d bytes=%0d dur=%0d",
                                     got.pkts, got.bytes, got.dur);
                        end
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, report_q.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed sequences at the reset defaults
        set_config(GAP_RESET, MINP_RESET);
        push_pkt(1'b1, 1'b1, 16'd100, 63'd0);         // candidate at time zero
        push_pkt(1'b0, 1'b1, 16'hFFFF, 63'd10);
        push_pkt(1'b0, 1'b1, 16'hFFFF, 63'd20);
        push_pkt(1'b0, 1'b1, 16'hFFFF, 63'd30);       // reaches the minimum
        push_pkt(1'b0, 1'b1, 16'd0, 63'd40);          // empty payload
        push_pkt(1'b0, 1'b1, 16'd1, 63'd50);          // adds to the counted bulk
        push_pkt(1'b0, 1'b0, 16'd500, 63'd60);        // backward traffic
        push_pkt(1'b0, 1'b1, 16'd10, 63'd70);         // forward candidate abandoned
        push_pkt(1'b0, 1'b1, 16'd10, 63'd1000071);    // one past the gap limit
        push_pkt(1'b0, 1'b1, 16'd10, 63'd2000071);    // exactly at the gap limit
        push_pkt(1'b0, 1'b1, 16'd10, 63'd1999000);    // time going backward
        push_pkt(1'b0, 1'b1, 16'd10, 63'd1999500);
        push_pkt(1'b1, 1'b1, 16'd7, 63'd5000);
        push_pkt(1'b0, 1'b1, 16'd7, 63'd4000);
        push_pkt(1'b0, 1'b1, 16'd7, 63'd3000);
        push_pkt(1'b0, 1'b1, 16'd7, 63'd2000);        // bulk with negative duration
        push_pkt(1'b0, 1'b1, 16'hFFFF, TS_MAX);
        for (int i = 0; i < 4; i++)
            push_pkt(1'b0, 1'b0, 16'hFFFF, TS_MAX);
        push_pkt(1'b1, 1'b0, 16'd0, 63'd0);
        push_pkt(1'b1, 1'b1, 16'd3, 63'd5);
        drain();

        set_config(32'd50, 8'd3);
        gen_traffic(150, 1, 12, 15);
        drain();

        // widest gap, largest minimum: long clean runs of one direction
        set_config(32'hFFFF_FFFF, 8'hFF);
        send_idle_pct = 62;
        gen_traffic(300, 285, 300, 0);
        drain();

        // zero gap and a minimum below the floor
        set_config(32'd0, 8'd0);
        send_idle_pct = 0;
        recv_stall_pct = 62;
        gen_traffic(120, 1, 8, 15);
        drain();

        set_config(32'd200000, 8'd1);
        send_idle_pct = 9;
        recv_stall_pct = 9;
        gen_traffic(150, 1, 20, 20);
        drain();

        set_config(32'd1000, 8'd5);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        gen_traffic(100, 1, 30, 10);
        drain();
        repeat (8) @(posedge clk);

        $display("Sent %0d packets over %0d register settings and stall mixes;",
                 packets_in, settings_run);
        $display("checked %0d results, %0d of them inside an open bulk, %0d mismatching.",
                 results_in, bulk_reports, mismatches);
        if (mismatches == 0 && report_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
